FILE: src/pcr_pkg.sv
`default_nettype none

package pcr_pkg;

   // fixed field widths
   localparam int VEC_BITS     = 63;
   localparam int MASS_BITS    = 24;
   localparam int TOTAL_BITS   = MASS_BITS + 1;
   localparam int PEN_BITS     = 21;
   localparam int RES_BITS     = 17;
   localparam int STEP_BITS    = 16;
   localparam int SCALE_BITS   = 16;
   localparam int CSR_IDX_BITS = 1;

   // velocity change limit and share arithmetic widths
   localparam int NUM_BITS  = 38;
   localparam int HALF_BITS = NUM_BITS / 2;
   localparam int PROD_BITS = NUM_BITS + MASS_BITS;

   // register reset values
   localparam logic [RES_BITS-1:0]  RESTITUTION_RESET = 17'd65536;
   localparam logic [STEP_BITS-1:0] STEP_RESET        = 16'd1092;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_RESTITUTION   = 1'b0,
      CSR_STEP_DURATION = 1'b1
   } csr_index_type;

   // what the apply lanes must know about one contact
   typedef struct packed {
      logic impulse;
      logic moved;
      logic has_second;
   } apply_ctrl_type;

   // per-particle shares of one scalar
   typedef struct packed {
      logic [NUM_BITS-1:0] share_a;
      logic [NUM_BITS-1:0] share_b;
   } share_type;

endpackage

`default_nettype wire

FILE: src/pcr_dot_lane.sv
`default_nettype none

module pcr_dot_lane #(
   parameter int W = 21
) (
   input  wire logic                   clock,
   input  wire logic signed [W-1:0]    va,
   input  wire logic signed [W-1:0]    vb,
   input  wire logic signed [W-1:0]    aa,
   input  wire logic signed [W-1:0]    ab,
   input  wire logic signed [W-1:0]    n,
   input  wire logic                   has_second,
   output logic signed [2*W:0]         prod_v,
   output logic signed [2*W:0]         prod_a
);

   logic signed [W:0]   rv;
   logic signed [W:0]   ra;
   logic signed [2*W:0] prod_v_ff;
   logic signed [2*W:0] prod_a_ff;

   // relative velocity and acceleration of this component
   always_comb begin
      rv = (W+1)'(va) - (has_second ? (W+1)'(vb) : '0);
      ra = (W+1)'(aa) - (has_second ? (W+1)'(ab) : '0);
   end

   // component products against the normal
   always_ff @(posedge clock) begin
      prod_v_ff <= rv * (W+1)'(n);
      prod_a_ff <= ra * (W+1)'(n);
   end

   assign prod_v = prod_v_ff;
   assign prod_a = prod_a_ff;

endmodule

`default_nettype wire

FILE: src/pcr_share_div.sv
`default_nettype none

module pcr_share_div
   import pcr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic [NUM_BITS-1:0]   num,
   input  wire logic [MASS_BITS-1:0]  mass,
   input  wire logic [TOTAL_BITS-1:0] total,
   output share_type                  share
);

   localparam int PP_BITS = HALF_BITS + MASS_BITS;

   typedef struct packed {
      logic [TOTAL_BITS-1:0] rem;
      logic [PROD_BITS-1:0]  prod;
      logic [NUM_BITS-1:0]   quo;
      logic [NUM_BITS-1:0]   num;
      logic [TOTAL_BITS-1:0] total;
   } div_stage_type;

   logic [PP_BITS-1:0]    p_lo_ff;
   logic [PP_BITS-1:0]    p_hi_ff;
   logic [NUM_BITS-1:0]   num_ff;
   logic [TOTAL_BITS-1:0] total_ff;
   logic [PROD_BITS-1:0]  prod;
   div_stage_type         stage_ff [0:NUM_BITS];

   // numerator times mass in two halves
   always_ff @(posedge clock) begin
      p_lo_ff  <= PP_BITS'(num[HALF_BITS-1:0]) * PP_BITS'(mass);
      p_hi_ff  <= PP_BITS'(num[NUM_BITS-1:HALF_BITS]) * PP_BITS'(mass);
      num_ff   <= num;
      total_ff <= total;
   end

   assign prod = {p_hi_ff[PROD_BITS-HALF_BITS-1:0], {HALF_BITS{1'b0}}}
               + PROD_BITS'(p_lo_ff);

   // quotient fits the numerator width, so the top bits start the remainder
   always_ff @(posedge clock) begin
      stage_ff[0].rem   <= TOTAL_BITS'(prod[PROD_BITS-1:NUM_BITS]);
      stage_ff[0].prod  <= prod;
      stage_ff[0].quo   <= '0;
      stage_ff[0].num   <= num_ff;
      stage_ff[0].total <= total_ff;
   end

   // one quotient bit per stage, restoring
   for (genvar k = 1; k <= NUM_BITS; k++) begin : g_div
      logic [TOTAL_BITS:0] trial;
      logic                take;

      always_comb begin
         trial = {stage_ff[k-1].rem, stage_ff[k-1].prod[NUM_BITS-k]};
         take  = trial >= {1'b0, stage_ff[k-1].total};
      end

      always_ff @(posedge clock) begin
         stage_ff[k].rem   <= take ? TOTAL_BITS'(trial - {1'b0, stage_ff[k-1].total})
                                   : TOTAL_BITS'(trial);
         stage_ff[k].prod  <= stage_ff[k-1].prod;
         stage_ff[k].quo   <= stage_ff[k-1].quo | (NUM_BITS'(take) << (NUM_BITS-k));
         stage_ff[k].num   <= stage_ff[k-1].num;
         stage_ff[k].total <= stage_ff[k-1].total;
      end
   end

   // the other share is the rest, rounded down
   always_comb begin
      share.share_a = stage_ff[NUM_BITS].quo;
      share.share_b = stage_ff[NUM_BITS].num - stage_ff[NUM_BITS].quo
                    - NUM_BITS'(|stage_ff[NUM_BITS].rem);
   end

endmodule

`default_nettype wire

FILE: src/pcr_apply_lane.sv
`default_nettype none

module pcr_apply_lane
   import pcr_pkg::*;
#(
   parameter int W = 21,
   parameter int F = 10
) (
   input  wire logic                clock,
   input  wire logic signed [W-1:0] n,
   input  wire logic signed [W-1:0] va,
   input  wire logic signed [W-1:0] vb,
   input  wire logic signed [W-1:0] pa,
   input  wire logic signed [W-1:0] pb,
   input  wire share_type           vel,
   input  wire share_type           pen,
   input  wire apply_ctrl_type      ctrl,
   output logic [W-1:0]             new_va,
   output logic [W-1:0]             new_vb,
   output logic [W-1:0]             new_pa,
   output logic [W-1:0]             new_pb,
   output logic [W-1:0]             move_a,
   output logic [W-1:0]             move_b
);

   localparam int PL = W + HALF_BITS + 1;
   localparam int LW = W + NUM_BITS + 3;
   localparam logic signed [LW-1:0] SAT_HI = LW'((1 << (W-1)) - 1);
   localparam logic signed [LW-1:0] SAT_LO = -SAT_HI - LW'(1);

   logic signed [PL-1:0] pva_lo_ff, pva_hi_ff, pvb_lo_ff, pvb_hi_ff;
   logic signed [PL-1:0] ppa_lo_ff, ppa_hi_ff, ppb_lo_ff, ppb_hi_ff;
   logic signed [W-1:0]  va_ff, vb_ff, pa_ff, pb_ff;
   apply_ctrl_type       ctrl_ff;

   logic signed [LW-1:0] da_v, db_v, da_p, db_p;
   logic signed [W-1:0]  ma, mb;
   logic [W-1:0] new_va_ff, new_vb_ff, new_pa_ff, new_pb_ff, move_a_ff, move_b_ff;

   function automatic logic signed [PL-1:0] part(input logic signed [W-1:0] c,
                                                 input logic [HALF_BITS-1:0] h);
      logic signed [PL-1:0] hs;
      hs = $signed(PL'(h));
      return PL'(c) * hs;
   endfunction

   function automatic logic signed [LW-1:0] join_parts(input logic signed [PL-1:0] hi,
                                                       input logic signed [PL-1:0] lo);
      return (LW'(hi) <<< HALF_BITS) + LW'(lo);
   endfunction

   function automatic logic signed [W-1:0] sat(input logic signed [LW-1:0] x);
      logic signed [LW-1:0] r;
      r = x;
      if (x > SAT_HI) r = SAT_HI;
      else if (x < SAT_LO) r = SAT_LO;
      return r[W-1:0];
   endfunction

   // split products of the normal and each share
   always_ff @(posedge clock) begin
      pva_lo_ff <= part(n, vel.share_a[HALF_BITS-1:0]);
      pva_hi_ff <= part(n, vel.share_a[NUM_BITS-1:HALF_BITS]);
      pvb_lo_ff <= part(n, vel.share_b[HALF_BITS-1:0]);
      pvb_hi_ff <= part(n, vel.share_b[NUM_BITS-1:HALF_BITS]);
      ppa_lo_ff <= part(n, pen.share_a[HALF_BITS-1:0]);
      ppa_hi_ff <= part(n, pen.share_a[NUM_BITS-1:HALF_BITS]);
      ppb_lo_ff <= part(n, pen.share_b[HALF_BITS-1:0]);
      ppb_hi_ff <= part(n, pen.share_b[NUM_BITS-1:HALF_BITS]);
      va_ff     <= va;
      vb_ff     <= vb;
      pa_ff     <= pa;
      pb_ff     <= pb;
      ctrl_ff   <= ctrl;
   end

   // scaled changes, b side pushed the other way
   always_comb begin
      da_v = join_parts(pva_hi_ff, pva_lo_ff) >>> F;
      db_v = (-join_parts(pvb_hi_ff, pvb_lo_ff)) >>> F;
      da_p = join_parts(ppa_hi_ff, ppa_lo_ff) >>> F;
      db_p = (-join_parts(ppb_hi_ff, ppb_lo_ff)) >>> F;
      ma   = (ctrl_ff.moved) ? sat(da_p) : '0;
      mb   = (ctrl_ff.moved && ctrl_ff.has_second) ? sat(db_p) : '0;
   end

   // saturated results, pass-through where nothing applies
   always_ff @(posedge clock) begin
      new_va_ff <= ctrl_ff.impulse ? sat(LW'(va_ff) + da_v) : va_ff;
      new_vb_ff <= (ctrl_ff.impulse && ctrl_ff.has_second) ? sat(LW'(vb_ff) + db_v) : vb_ff;
      new_pa_ff <= ctrl_ff.moved ? sat(LW'(pa_ff) + LW'(ma)) : pa_ff;
      new_pb_ff <= (ctrl_ff.moved && ctrl_ff.has_second) ? sat(LW'(pb_ff) + LW'(mb)) : pb_ff;
      move_a_ff <= ma;
      move_b_ff <= mb;
   end

   assign new_va = new_va_ff;
   assign new_vb = new_vb_ff;
   assign new_pa = new_pa_ff;
   assign new_pb = new_pb_ff;
   assign move_a = move_a_ff;
   assign move_b = move_b_ff;

endmodule

`default_nettype wire

FILE: src/particle_contact_resolve_unit.sv
`default_nettype none

// Resolves one particle contact per clock. A contact is taken when start is
// high and busy is low; busy is high only in the cycle after reset, so a new
// contact may follow every cycle. Its result appears with rsp_valid high for
// exactly one cycle and must be taken then: the block has no way to hold it.
// A 38-step pipelined divider splits the velocity change and the penetration
// between the two particles; the three vector components run in parallel
// lanes. The user must write restitution and step duration through the csr
// port only while no contact is in flight; the block does not enforce this.
module particle_contact_resolve_unit
   import pcr_pkg::*;
#(
   parameter int COMPONENT_WIDTH = 21,
   parameter int FRACTION_BITS   = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [VEC_BITS-1:0]     req_velocity_a,
   input  wire logic [VEC_BITS-1:0]     req_velocity_b,
   input  wire logic [VEC_BITS-1:0]     req_accel_a,
   input  wire logic [VEC_BITS-1:0]     req_accel_b,
   input  wire logic [VEC_BITS-1:0]     req_contact_normal,
   input  wire logic [VEC_BITS-1:0]     req_position_a,
   input  wire logic [VEC_BITS-1:0]     req_position_b,
   input  wire logic [MASS_BITS-1:0]    req_inv_mass_a,
   input  wire logic [MASS_BITS-1:0]    req_inv_mass_b,
   input  wire logic signed [PEN_BITS-1:0] req_penetration,
   input  wire logic                    req_has_second,
   output logic                         rsp_valid,
   output logic [VEC_BITS-1:0]          rsp_new_velocity_a,
   output logic [VEC_BITS-1:0]          rsp_new_velocity_b,
   output logic [VEC_BITS-1:0]          rsp_new_position_a,
   output logic [VEC_BITS-1:0]          rsp_new_position_b,
   output logic [VEC_BITS-1:0]          rsp_move_a,
   output logic [VEC_BITS-1:0]          rsp_move_b,
   output logic                         rsp_impulse_applied,
   output logic                         rsp_moved,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [RES_BITS-1:0]     csr_data
);

   localparam int W  = COMPONENT_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int PW = 2*W + 1;
   localparam int DW = 2*W + 3;
   localparam int XW = (2*W + 8 > NUM_BITS + 2) ? 2*W + 8 : NUM_BITS + 2;
   localparam int SIDE_DEPTH  = 47;
   localparam int VALID_DEPTH = 49;
   localparam int IMP_DEPTH   = 44;
   localparam logic signed [XW-1:0] DV_LIMIT = XW'((64'd1 << NUM_BITS) - 64'd1);

   typedef struct packed {
      logic [VEC_BITS-1:0]   va;
      logic [VEC_BITS-1:0]   vb;
      logic [VEC_BITS-1:0]   pa;
      logic [VEC_BITS-1:0]   pb;
      logic [VEC_BITS-1:0]   n;
      logic [PEN_BITS-1:0]   pen;
      logic [MASS_BITS-1:0]  ima;
      logic [TOTAL_BITS-1:0] total;
      logic                  has;
      logic                  mov;
   } side_type;

   logic                  busy_ff;
   logic [RES_BITS-1:0]   restitution_ff;
   logic [STEP_BITS-1:0]  step_ff;
   side_type              side_in;
   side_type              side_ff [0:SIDE_DEPTH-1];
   logic [VEC_BITS-1:0]   aa_ff, ab_ff;
   logic                  valid_ff [0:VALID_DEPTH-1];
   logic                  imp_ff [0:IMP_DEPTH-1];

   logic signed [PW-1:0]  prod_v [3];
   logic signed [PW-1:0]  prod_a [3];
   logic signed [DW-1:0]  dot_ff, accdot_ff;

   logic signed [XW-1:0]          sep, accd;
   logic signed [XW+RES_BITS:0]   prod1_ff, prod3_ff;
   logic signed [XW+STEP_BITS:0]  prod2_ff;
   logic signed [XW-1:0]          sep_b_ff, sep_c_ff, sep_d_ff;
   logic signed [XW-1:0]          newsep0_ff, newsep0_d_ff, accsep_ff;
   logic                          acc_neg_ff;
   logic signed [XW-1:0]          adj, newsep, dv;
   logic [NUM_BITS-1:0]           dv_ff;

   share_type             vel_share, pen_share;
   apply_ctrl_type        ctrl_a, ctrl_s1_ff, ctrl_s2_ff;

   logic [3*W-1:0] nva_cat, nvb_cat, npa_cat, npb_cat, ma_cat, mb_cat;

   // busy only right after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end
   assign busy = busy_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= RESTITUTION_RESET;
         step_ff        <= STEP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_RESTITUTION:   restitution_ff <= csr_data;
            CSR_STEP_DURATION: step_ff        <= csr_data[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // beat capture with total mass and move decision
   always_comb begin
      side_in.va    = req_velocity_a;
      side_in.vb    = req_velocity_b;
      side_in.pa    = req_position_a;
      side_in.pb    = req_position_b;
      side_in.n     = req_contact_normal;
      side_in.pen   = req_penetration;
      side_in.ima   = req_inv_mass_a;
      side_in.total = TOTAL_BITS'(req_inv_mass_a)
                    + (req_has_second ? TOTAL_BITS'(req_inv_mass_b) : '0);
      side_in.has   = req_has_second;
      side_in.mov   = (req_penetration > 0) && (side_in.total != '0);
   end

   // sideband delay line, valid line and impulse flag line
   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      aa_ff      <= req_accel_a;
      ab_ff      <= req_accel_b;
      for (int i = 1; i < SIDE_DEPTH; i++) side_ff[i] <= side_ff[i-1];
      imp_ff[0] <= (dot_ff <= 0) && (side_ff[2].total != '0);
      for (int i = 1; i < IMP_DEPTH; i++) imp_ff[i] <= imp_ff[i-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VALID_DEPTH; i++) valid_ff[i] <= 1'b0;
      end else begin
         valid_ff[0] <= start && !busy_ff;
         for (int i = 1; i < VALID_DEPTH; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // per-component dot product lanes
   for (genvar g = 0; g < 3; g++) begin : g_dot
      pcr_dot_lane #(.W(W)) u_dot (
         .clock      (clock),
         .va         ($signed(side_ff[0].va[g*W +: W])),
         .vb         ($signed(side_ff[0].vb[g*W +: W])),
         .aa         ($signed(aa_ff[g*W +: W])),
         .ab         ($signed(ab_ff[g*W +: W])),
         .n          ($signed(side_ff[0].n[g*W +: W])),
         .has_second (side_ff[0].has),
         .prod_v     (prod_v[g]),
         .prod_a     (prod_a[g])
      );
   end

   // merge lane products
   always_ff @(posedge clock) begin
      dot_ff    <= DW'(prod_v[0]) + DW'(prod_v[1]) + DW'(prod_v[2]);
      accdot_ff <= DW'(prod_a[0]) + DW'(prod_a[1]) + DW'(prod_a[2]);
   end

   // restitution target and acceleration build-up
   always_comb begin
      sep  = XW'(dot_ff) >>> F;
      accd = XW'(accdot_ff) >>> F;
   end

   always_ff @(posedge clock) begin
      prod1_ff <= (XW+RES_BITS+1)'(-sep) * $signed((XW+RES_BITS+1)'(restitution_ff));
      prod2_ff <= (XW+STEP_BITS+1)'(accd) * $signed((XW+STEP_BITS+1)'(step_ff));
      sep_b_ff <= sep;
   end

   always_ff @(posedge clock) begin
      newsep0_ff <= XW'(prod1_ff >>> SCALE_BITS);
      accsep_ff  <= XW'(prod2_ff >>> SCALE_BITS);
      sep_c_ff   <= sep_b_ff;
   end

   always_ff @(posedge clock) begin
      prod3_ff     <= (XW+RES_BITS+1)'(accsep_ff) * $signed((XW+RES_BITS+1)'(restitution_ff));
      acc_neg_ff   <= accsep_ff < 0;
      newsep0_d_ff <= newsep0_ff;
      sep_d_ff     <= sep_c_ff;
   end

   // velocity change with clamps
   always_comb begin
      adj    = XW'(prod3_ff >>> SCALE_BITS);
      newsep = newsep0_d_ff;
      if (acc_neg_ff) begin
         newsep = newsep0_d_ff + adj;
         if (newsep < 0) newsep = '0;
      end
      dv = newsep - sep_d_ff;
      if (dv > DV_LIMIT) dv = DV_LIMIT;
   end

   always_ff @(posedge clock) begin
      dv_ff <= dv[NUM_BITS-1:0];
   end

   // mass-proportional shares for impulse and penetration
   pcr_share_div u_vel_div (
      .clock (clock),
      .num   (dv_ff),
      .mass  (side_ff[6].ima),
      .total (side_ff[6].total),
      .share (vel_share)
   );

   pcr_share_div u_pen_div (
      .clock (clock),
      .num   (NUM_BITS'(side_ff[6].pen)),
      .mass  (side_ff[6].ima),
      .total (side_ff[6].total),
      .share (pen_share)
   );

   // control for the apply lanes and the flag outputs
   always_comb begin
      ctrl_a.impulse    = imp_ff[IMP_DEPTH-1];
      ctrl_a.moved      = side_ff[SIDE_DEPTH-1].mov;
      ctrl_a.has_second = side_ff[SIDE_DEPTH-1].has;
   end

   always_ff @(posedge clock) begin
      ctrl_s1_ff <= ctrl_a;
      ctrl_s2_ff <= ctrl_s1_ff;
   end

   // per-component apply lanes
   for (genvar g = 0; g < 3; g++) begin : g_apply
      pcr_apply_lane #(.W(W), .F(F)) u_apply (
         .clock  (clock),
         .n      ($signed(side_ff[SIDE_DEPTH-1].n[g*W +: W])),
         .va     ($signed(side_ff[SIDE_DEPTH-1].va[g*W +: W])),
         .vb     ($signed(side_ff[SIDE_DEPTH-1].vb[g*W +: W])),
         .pa     ($signed(side_ff[SIDE_DEPTH-1].pa[g*W +: W])),
         .pb     ($signed(side_ff[SIDE_DEPTH-1].pb[g*W +: W])),
         .vel    (vel_share),
         .pen    (pen_share),
         .ctrl   (ctrl_a),
         .new_va (nva_cat[g*W +: W]),
         .new_vb (nvb_cat[g*W +: W]),
         .new_pa (npa_cat[g*W +: W]),
         .new_pb (npb_cat[g*W +: W]),
         .move_a (ma_cat[g*W +: W]),
         .move_b (mb_cat[g*W +: W])
      );
   end

   // result beat
   assign rsp_valid           = valid_ff[VALID_DEPTH-1];
   assign rsp_new_velocity_a  = VEC_BITS'(nva_cat);
   assign rsp_new_velocity_b  = VEC_BITS'(nvb_cat);
   assign rsp_new_position_a  = VEC_BITS'(npa_cat);
   assign rsp_new_position_b  = VEC_BITS'(npb_cat);
   assign rsp_move_a          = VEC_BITS'(ma_cat);
   assign rsp_move_b          = VEC_BITS'(mb_cat);
   assign rsp_impulse_applied = ctrl_s2_ff.impulse;
   assign rsp_moved           = ctrl_s2_ff.moved;

endmodule

`default_nettype wire
